[design/xysq_pkg.sv]
// ----------------------------------------------------------------------------
// xysq_pkg
// shared widths, register indexes, step codes and the direction encoder
// ----------------------------------------------------------------------------
package xysq_pkg;

   localparam int POS_WIDTH_DEF = 32;   // default internal position width
   localparam int POS_FIELD_W   = 32;   // width of the position request fields
   localparam int CFG_W         = 16;   // width of every configuration register
   localparam int ELAPSED_W     = 32;   // elapsed time accumulator width
   localparam int CODE_W        = 4;    // step code width
   localparam int CSR_IDX_W     = 2;    // configuration index width

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SIZE_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SIZE_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_TIME   = 2'd2;

   // combined direction codes
   localparam logic [CODE_W-1:0] STEP_NONE   = 4'd0;
   localparam logic [CODE_W-1:0] STEP_PX     = 4'd1;
   localparam logic [CODE_W-1:0] STEP_PX_PY  = 4'd2;
   localparam logic [CODE_W-1:0] STEP_PY     = 4'd3;
   localparam logic [CODE_W-1:0] STEP_NX_PY  = 4'd4;
   localparam logic [CODE_W-1:0] STEP_NX     = 4'd5;
   localparam logic [CODE_W-1:0] STEP_NX_NY  = 4'd6;
   localparam logic [CODE_W-1:0] STEP_NY     = 4'd7;
   localparam logic [CODE_W-1:0] STEP_PX_NY  = 4'd8;
   localparam logic [CODE_W-1:0] STEP_CODE_MAX = STEP_PX_NY;

   // per-axis decision handed from an axis unit to the top level
   typedef struct packed {
      logic step;
      logic up;
   } axis_step_type;

   function automatic logic [CODE_W-1:0] encode_step(input axis_step_type x,
                                                     input axis_step_type y);
      logic [CODE_W-1:0] code;
      code = STEP_NONE;
      if (x.step && !y.step) begin
         code = x.up ? STEP_PX : STEP_NX;
      end else if (!x.step && y.step) begin
         code = y.up ? STEP_PY : STEP_NY;
      end else if (x.step && y.step) begin
         if (x.up == y.up) begin
            code = x.up ? STEP_PX_PY : STEP_NX_NY;
         end else begin
            code = y.up ? STEP_NX_PY : STEP_PX_NY;
         end
      end
      return code;
   endfunction

endpackage

[design/xysq_axis.sv]
// ----------------------------------------------------------------------------
// xysq_axis
// commanded step position of one axis and its step decision
// ----------------------------------------------------------------------------
module xysq_axis #(
   parameter int POS_WIDTH = xysq_pkg::POS_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         clear,
   input  logic signed [POS_WIDTH-1:0]  pos,
   input  logic [xysq_pkg::CFG_W-1:0]   step_size,
   output xysq_pkg::axis_step_type      decision
);

   localparam int DW = POS_WIDTH + 1;

   logic signed [POS_WIDTH-1:0] commanded_ff;
   logic signed [POS_WIDTH-1:0] commanded_in;
   logic signed [POS_WIDTH-1:0] base;
   logic signed [DW-1:0]        diff;
   logic signed [DW-1:0]        size_s;
   logic signed [DW-1:0]        moved;
   logic                        go_up;
   logic                        go_down;

   always_comb begin
      base    = clear ? '0 : commanded_ff;
      size_s  = $signed({{(DW-xysq_pkg::CFG_W){1'b0}}, step_size});
      diff    = $signed({pos[POS_WIDTH-1], pos}) - $signed({base[POS_WIDTH-1], base});
      go_up   = diff > size_s;
      go_down = diff < -size_s;
      if (go_up) begin
         moved = $signed({base[POS_WIDTH-1], base}) + size_s;
      end else if (go_down) begin
         moved = $signed({base[POS_WIDTH-1], base}) - size_s;
      end else begin
         moved = $signed({base[POS_WIDTH-1], base});
      end
      // commanded position stays inside the sample range, no wrap
      commanded_in  = moved[POS_WIDTH-1:0];
      decision.step = go_up | go_down;
      decision.up   = go_up;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         commanded_ff <= '0;
      end else if (advance) begin
         commanded_ff <= commanded_in;
      end
   end

endmodule

[design/xysq_elapsed.sv]
// ----------------------------------------------------------------------------
// xysq_elapsed
// saturating time accumulator, sampled and cleared on each step
// ----------------------------------------------------------------------------
module xysq_elapsed (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic                            clear,
   input  logic                            stepped,
   input  logic [xysq_pkg::CFG_W-1:0]      tick_time,
   output logic [xysq_pkg::ELAPSED_W-1:0]  elapsed
);

   logic [xysq_pkg::ELAPSED_W-1:0] acc_ff;
   logic [xysq_pkg::ELAPSED_W-1:0] acc_in;
   logic [xysq_pkg::ELAPSED_W-1:0] base;
   logic [xysq_pkg::ELAPSED_W-1:0] kept;
   logic [xysq_pkg::ELAPSED_W:0]   sum;

   always_comb begin
      base    = clear ? '0 : acc_ff;
      elapsed = stepped ? base : '0;
      kept    = stepped ? '0 : base;
      sum     = {1'b0, kept}
              + {{(xysq_pkg::ELAPSED_W + 1 - xysq_pkg::CFG_W){1'b0}}, tick_time};
      // hold at all ones instead of wrapping
      acc_in  = sum[xysq_pkg::ELAPSED_W] ? '1 : sum[xysq_pkg::ELAPSED_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (advance) begin
         acc_ff <= acc_in;
      end
   end

endmodule

[design/xy_step_direction_quantizer_core.sv]
// ----------------------------------------------------------------------------
// xy_step_direction_quantizer_core
// turns X/Y position samples into combined step/direction codes with the
// time elapsed since the previous step
// ----------------------------------------------------------------------------
//
//   channel | ports                                              | direction
//   --------+----------------------------------------------------+-----------
//   request | req_valid/req_ready, req_pos_x/y, req_move_start   | in
//   result  | rsp_valid/rsp_ready, rsp_step_code, rsp_elapsed_time | out
//   csr     | csr_we, csr_index, csr_wdata                       | in
//
// - one request per cycle while rsp_ready is high; path: request reg, result reg
// - the single pass from the request register to the result register sets the
//   rate: position compare, commanded update and elapsed update all close there
// - synchronous reset clears commanded positions, the elapsed accumulator and
//   both valid flags; configuration registers return to 1
// - a stalled result holds the request register; req_ready drops only when
//   both registers are full and rsp_ready is low
// ----------------------------------------------------------------------------
module xy_step_direction_quantizer_core #(
   parameter int POS_WIDTH = xysq_pkg::POS_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [xysq_pkg::POS_FIELD_W-1:0]  req_pos_x,
   input  logic [xysq_pkg::POS_FIELD_W-1:0]  req_pos_y,
   input  logic                              req_move_start,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [xysq_pkg::CODE_W-1:0]       rsp_step_code,
   output logic [xysq_pkg::ELAPSED_W-1:0]    rsp_elapsed_time,
   // configuration port
   input  logic                              csr_we,
   input  logic [xysq_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [xysq_pkg::CFG_W-1:0]        csr_wdata
);

   // configuration registers
   logic [xysq_pkg::CFG_W-1:0] step_size_x_ff;
   logic [xysq_pkg::CFG_W-1:0] step_size_y_ff;
   logic [xysq_pkg::CFG_W-1:0] tick_time_ff;

   // request register
   logic                             req_valid_ff;
   logic [xysq_pkg::POS_FIELD_W-1:0] pos_x_ff;
   logic [xysq_pkg::POS_FIELD_W-1:0] pos_y_ff;
   logic                             move_start_ff;

   // result register
   logic                             rsp_valid_ff;
   logic [xysq_pkg::CODE_W-1:0]      step_code_ff;
   logic [xysq_pkg::ELAPSED_W-1:0]   elapsed_ff;

   logic                             advance;
   logic                             take_req;
   logic signed [POS_WIDTH-1:0]      pos_x_ext;
   logic signed [POS_WIDTH-1:0]      pos_y_ext;
   xysq_pkg::axis_step_type          x_dec;
   xysq_pkg::axis_step_type          y_dec;
   logic [xysq_pkg::CODE_W-1:0]      step_code_in;
   logic [xysq_pkg::ELAPSED_W-1:0]   elapsed_in;

   // request moves into the result register when that is empty or draining
   assign advance   = req_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~req_valid_ff | advance;
   assign take_req  = req_valid & req_ready;

   // position fields read as POS_WIDTH-bit signed numbers; a wider internal
   // width sees the 32-bit field as unsigned
   generate
      if (POS_WIDTH <= xysq_pkg::POS_FIELD_W) begin : g_pos_narrow
         assign pos_x_ext = $signed(pos_x_ff[POS_WIDTH-1:0]);
         assign pos_y_ext = $signed(pos_y_ff[POS_WIDTH-1:0]);
      end else begin : g_pos_wide
         assign pos_x_ext = $signed({{(POS_WIDTH-xysq_pkg::POS_FIELD_W){1'b0}}, pos_x_ff});
         assign pos_y_ext = $signed({{(POS_WIDTH-xysq_pkg::POS_FIELD_W){1'b0}}, pos_y_ff});
      end
   endgenerate

   xysq_axis #(
      .POS_WIDTH (POS_WIDTH)
   ) u_axis_x (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .clear     (move_start_ff),
      .pos       (pos_x_ext),
      .step_size (step_size_x_ff),
      .decision  (x_dec)
   );

   xysq_axis #(
      .POS_WIDTH (POS_WIDTH)
   ) u_axis_y (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .clear     (move_start_ff),
      .pos       (pos_y_ext),
      .step_size (step_size_y_ff),
      .decision  (y_dec)
   );

   assign step_code_in = xysq_pkg::encode_step(x_dec, y_dec);

   // elapsed time reported only on a step, accumulator restarts there
   xysq_elapsed u_elapsed (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .clear     (move_start_ff),
      .stepped   (x_dec.step | y_dec.step),
      .tick_time (tick_time_ff),
      .elapsed   (elapsed_in)
   );

   // configuration writes, unknown index ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         step_size_x_ff <= 16'd1;
         step_size_y_ff <= 16'd1;
         tick_time_ff   <= 16'd1;
      end else if (csr_we) begin
         case (csr_index)
            xysq_pkg::CSR_STEP_SIZE_X: step_size_x_ff <= csr_wdata;
            xysq_pkg::CSR_STEP_SIZE_Y: step_size_y_ff <= csr_wdata;
            xysq_pkg::CSR_TICK_TIME:   tick_time_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // request register control
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (take_req) begin
         req_valid_ff <= 1'b1;
      end else if (advance) begin
         req_valid_ff <= 1'b0;
      end
   end

   // request payload
   always_ff @(posedge clock) begin
      if (take_req) begin
         pos_x_ff      <= req_pos_x;
         pos_y_ff      <= req_pos_y;
         move_start_ff <= req_move_start;
      end
   end

   // result register control
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (advance) begin
         step_code_ff <= step_code_in;
         elapsed_ff   <= elapsed_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_step_code    = step_code_ff;
   assign rsp_elapsed_time = elapsed_ff;

endmodule

[design/xysq_checker.sv]
// ----------------------------------------------------------------------------
// xysq_checker
// port-level checks of the quantizer core, bound to the top level
// ----------------------------------------------------------------------------
module xysq_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_ready,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [xysq_pkg::CODE_W-1:0]       rsp_step_code,
   input  logic [xysq_pkg::ELAPSED_W-1:0]    rsp_elapsed_time
);

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // step code stays in the defined range
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_step_code <= xysq_pkg::STEP_CODE_MAX)
      else $error("step code out of range");

   // elapsed time only reported with a step
   a_no_step_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_step_code == xysq_pkg::STEP_NONE) |-> rsp_elapsed_time == '0)
      else $error("elapsed time without a step");

   // back-pressure only when a result is stuck
   a_ready_only_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request stalled without a stuck result");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_step_code) && $stable(rsp_elapsed_time)))
      else $error("stalled result changed");

endmodule

bind xy_step_direction_quantizer_core xysq_checker u_xysq_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_step_code    (rsp_step_code),
   .rsp_elapsed_time (rsp_elapsed_time)
);

[test/xy_step_direction_quantizer_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xy_step_direction_quantizer_core_test
// self-checking bench for the X/Y step quantizer: a stimulus table, a no-step
// run that builds up elapsed time, then random moves and noise, with every
// result checked against its table row or a cycle-free model of the step decision
// ----------------------------------------------------------------------------
module xy_step_direction_quantizer_core_test;

   // index with no register behind it, writes there must be dropped
   localparam logic [xysq_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] POS_MIN = 32'h8000_0000;
   localparam longint WALK_MAX = 64'sd2147483647;
   localparam longint WALK_MIN = -64'sd2147483648;

   localparam int RANDOM_ITEMS = 1050;
   localparam int CALM_TAIL    = 150;     // last random requests run without idling
   localparam int PRESSURE_AT  = 300;     // random request count that starts the long hold
   localparam int LONG_HOLD    = 300;     // cycles the result side holds off
   localparam int QUIET_RUN    = 100;     // no-step samples before the reporting step
   localparam int TAIL_CYCLES  = 8;       // extra idle cycles after the last owed result
   localparam int STALL_LIMIT  = 4000;    // cycles without any handshake

   typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_type;

   // one step of the stimulus table: a request or a register write
   typedef struct packed {
      row_kind_type                       kind;
      logic [31:0]                        x;
      logic [31:0]                        y;
      logic                               ms;
      logic                               typed;     // expected result given in the row
      logic [xysq_pkg::CODE_W-1:0]        code;
      logic [xysq_pkg::ELAPSED_W-1:0]     elapsed;
      logic [xysq_pkg::CSR_IDX_W-1:0]     idx;
      logic [xysq_pkg::CFG_W-1:0]         data;
   } plan_row_type;

   typedef struct packed {
      logic [xysq_pkg::CODE_W-1:0]        code;
      logic [xysq_pkg::ELAPSED_W-1:0]     elapsed;
   } step_result_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // block ports, inputs all known from time zero
   logic                                req_valid      = 1'b0;
   logic                                req_ready;
   logic [xysq_pkg::POS_FIELD_W-1:0]    req_pos_x      = '0;
   logic [xysq_pkg::POS_FIELD_W-1:0]    req_pos_y      = '0;
   logic                                req_move_start = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_ready      = 1'b1;
   logic [xysq_pkg::CODE_W-1:0]         rsp_step_code;
   logic [xysq_pkg::ELAPSED_W-1:0]      rsp_elapsed_time;
   logic                                csr_we         = 1'b0;
   logic [xysq_pkg::CSR_IDX_W-1:0]      csr_index      = '0;
   logic [xysq_pkg::CFG_W-1:0]          csr_wdata      = '0;

   xy_step_direction_quantizer_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_move_start   (req_move_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_step_code    (rsp_step_code),
      .rsp_elapsed_time (rsp_elapsed_time),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // model state: registers and the step tracker, same reset as the block
   logic [xysq_pkg::CFG_W-1:0]       size_x    = 16'd1;
   logic [xysq_pkg::CFG_W-1:0]       size_y    = 16'd1;
   logic [xysq_pkg::CFG_W-1:0]       tick_step = 16'd1;
   logic signed [33:0]               track_x   = '0;   // two spare bits keep pos - track exact
   logic signed [33:0]               track_y   = '0;
   logic [xysq_pkg::ELAPSED_W-1:0]   idle_time = '0;

   // results owed by the block, oldest first
   step_result_type pending_steps [$];

   int  fault_count  = 0;
   int  quiet_cycles = 0;
   int  send_quiet   = 0;
   int  random_count = 0;
   bit  calm         = 1'b0;
   bit  pressure_due = 1'b0;

   // one axis: step when the sample is more than a step size away, toward it
   function automatic void axis_decide(input logic signed [33:0] pos,
                                       input logic signed [33:0] held,
                                       input logic [xysq_pkg::CFG_W-1:0] size,
                                       output logic stepped, output logic up,
                                       output logic signed [33:0] held_next);
      logic signed [33:0] gap;
      logic [33:0]        gap_mag;
      gap       = pos - held;
      gap_mag   = (gap < 0) ? -gap : gap;
      stepped   = gap_mag > {18'd0, size};
      up        = stepped && (gap > 0);
      held_next = held;
      // a zero step size reports the step but the tracker stays put
      if (stepped && up) held_next = held + $signed({18'd0, size});
      else if (stepped) held_next = held - $signed({18'd0, size});
   endfunction

   // expected result of one request, advancing the model state
   function automatic step_result_type quantize_sample(input logic [31:0] px,
                                                       input logic [31:0] py,
                                                       input logic ms);
      step_result_type    r;
      logic               sx, ux, sy, uy;
      logic signed [33:0] nx, ny;
      logic [32:0]        sum;
      if (ms) begin
         track_x   = '0;
         track_y   = '0;
         idle_time = '0;
      end
      axis_decide($signed(px), track_x, size_x, sx, ux, nx);
      axis_decide($signed(py), track_y, size_y, sy, uy, ny);
      track_x = nx;
      track_y = ny;
      if (sx && sy) begin
         if (ux == uy) r.code = ux ? xysq_pkg::STEP_PX_PY : xysq_pkg::STEP_NX_NY;
         else r.code = uy ? xysq_pkg::STEP_NX_PY : xysq_pkg::STEP_PX_NY;
      end else if (sx) begin
         r.code = ux ? xysq_pkg::STEP_PX : xysq_pkg::STEP_NX;
      end else if (sy) begin
         r.code = uy ? xysq_pkg::STEP_PY : xysq_pkg::STEP_NY;
      end else begin
         r.code = xysq_pkg::STEP_NONE;
      end
      // elapsed is reported only with a step, and restarts from zero
      r.elapsed = '0;
      if (r.code != xysq_pkg::STEP_NONE) begin
         r.elapsed = idle_time;
         idle_time = '0;
      end
      // tick accumulates and sticks at all ones
      sum       = {1'b0, idle_time} + {17'd0, tick_step};
      idle_time = sum[32] ? '1 : sum[31:0];
      return r;
   endfunction

   function automatic plan_row_type sample_row(input logic [31:0] x, input logic [31:0] y,
                                               input logic ms);
      plan_row_type r;
      r      = '0;
      r.kind = ROW_SAMPLE;
      r.x    = x;
      r.y    = y;
      r.ms   = ms;
      return r;
   endfunction

   function automatic plan_row_type checked_row(input logic [31:0] x, input logic [31:0] y,
                                                input logic ms,
                                                input logic [xysq_pkg::CODE_W-1:0] code,
                                                input logic [xysq_pkg::ELAPSED_W-1:0] elapsed);
      plan_row_type r;
      r         = sample_row(x, y, ms);
      r.typed   = 1'b1;
      r.code    = code;
      r.elapsed = elapsed;
      return r;
   endfunction

   function automatic plan_row_type wr_row(input logic [xysq_pkg::CSR_IDX_W-1:0] idx,
                                           input logic [xysq_pkg::CFG_W-1:0] data);
      plan_row_type r;
      r      = '0;
      r.kind = ROW_WRITE;
      r.idx  = idx;
      r.data = data;
      return r;
   endfunction

   // register values: extremes often, small sizes mostly so steps are frequent
   function automatic logic [xysq_pkg::CFG_W-1:0] pick_setting();
      case ($urandom_range(0, 9))
         0:       return 16'd0;
         1:       return 16'd1;
         2:       return 16'hFFFF;
         3:       return 16'($urandom);
         default: return 16'($urandom_range(1, 300));
      endcase
   endfunction

   function automatic longint clamp_pos(input longint v);
      if (v > WALK_MAX) return WALK_MAX;
      if (v < WALK_MIN) return WALK_MIN;
      return v;
   endfunction

   // request side idling: random bursts, sometimes a quiet stretch after
   task automatic sender_gap();
      if (calm) return;
      if (send_quiet > 0) begin
         send_quiet--;
      end else if ($urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
         if ($urandom_range(0, 3) == 0) send_quiet = $urandom_range(20, 80);
      end
   endtask

   // stop offering and wait until every owed result has come back
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_steps.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // one table row: register writes only with the block drained
   task automatic run_row(input plan_row_type r);
      step_result_type predicted;
      step_result_type given;
      if (r.kind == ROW_WRITE) begin
         settle();
         csr_we    <= 1'b1;
         csr_index <= r.idx;
         csr_wdata <= r.data;
         @(posedge clock);
         csr_we <= 1'b0;
         case (r.idx)
            xysq_pkg::CSR_STEP_SIZE_X: size_x    = r.data;
            xysq_pkg::CSR_STEP_SIZE_Y: size_y    = r.data;
            xysq_pkg::CSR_TICK_TIME:   tick_step = r.data;
            default:                   ;
         endcase
      end else begin
         sender_gap();
         req_pos_x      <= r.x;
         req_pos_y      <= r.y;
         req_move_start <= r.ms;
         req_valid      <= 1'b1;
         do @(posedge clock); while (!req_ready);
         // request taken at this edge, model always advances
         predicted = quantize_sample(r.x, r.y, r.ms);
         if (r.typed) begin
            given.code    = r.code;
            given.elapsed = r.elapsed;
            pending_steps.push_back(given);
         end else begin
            pending_steps.push_back(predicted);
         end
      end
   endtask

   task automatic report_fault(input string what, input logic [31:0] want,
                               input logic [31:0] got);
      if (fault_count < 10)
         $display("mismatch on %s: expected %0h, got %0h", what, want, got);
      fault_count++;
   endtask

   // result checker, samples at the edge where the handshake completes
   always @(posedge clock) begin : result_check
      step_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_steps.size() == 0) begin
            report_fault("unexpected result code", '0, 32'(rsp_step_code));
         end else begin
            want = pending_steps.pop_front();
            if (rsp_step_code !== want.code)
               report_fault("step_code", 32'(want.code), 32'(rsp_step_code));
            if (rsp_elapsed_time !== want.elapsed)
               report_fault("elapsed_time", want.elapsed, rsp_elapsed_time);
         end
      end
   end

   // result side: short random stalls, quiet stretches, one long hold
   initial begin : rsp_throttle
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (pressure_due) begin
            // hold long enough for both internal registers to fill and
            // req_ready to drop while requests keep coming
            pressure_due = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (!calm && quiet == 0 && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) quiet = $urandom_range(30, 120);
         end else if (quiet > 0) begin
            quiet--;
         end
      end
   end

   // watchdog: too long with no handshake on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("xy_step_direction_quantizer_core_test: errors");
         $finish;
      end
   end

   initial begin : stimulus
      plan_row_type plan_rows [$];
      longint       walk_x, walk_y, span;
      int           seg_len;
      bit           wander, first;

      plan_rows = '{
         // out of reset: step sizes 1, tick 1, nothing to do at the origin
         checked_row(32'd0, 32'd0, 1'b0, xysq_pkg::STEP_NONE, 32'd0),
         // walk through every direction one unit step at a time
         sample_row(32'd2, 32'd0, 1'b0),
         sample_row(32'd0, 32'd2, 1'b0),
         sample_row(-32'sd1, -32'sd1, 1'b0),
         sample_row(-32'sd2, 32'd2, 1'b0),
         sample_row(-32'sd3, 32'd1, 1'b0),
         sample_row(-32'sd2, -32'sd1, 1'b0),
         sample_row(32'd0, -32'sd2, 1'b0),
         sample_row(32'd1, 32'd1, 1'b0),
         // position extremes, move start clears the elapsed time
         checked_row(POS_MAX, POS_MIN, 1'b1, xysq_pkg::STEP_PX_NY, 32'd0),
         checked_row(POS_MIN, POS_MAX, 1'b1, xysq_pkg::STEP_NX_PY, 32'd0),
         sample_row(POS_MIN, POS_MIN, 1'b0),
         checked_row(POS_MAX, POS_MAX, 1'b1, xysq_pkg::STEP_PX_PY, 32'd0),
         // a distance equal to the step size is not a step
         checked_row(32'd1, -32'sd1, 1'b1, xysq_pkg::STEP_NONE, 32'd0),
         sample_row(-32'sd1, 32'd1, 1'b0),
         // zero X step size, largest Y step size and tick
         wr_row(xysq_pkg::CSR_STEP_SIZE_X, 16'd0),
         wr_row(xysq_pkg::CSR_STEP_SIZE_Y, 16'hFFFF),
         wr_row(xysq_pkg::CSR_TICK_TIME, 16'hFFFF),
         checked_row(32'd1, 32'd0, 1'b1, xysq_pkg::STEP_PX, 32'd0),
         sample_row(32'd1, 32'd0, 1'b0),
         sample_row(-32'sd1, 32'd65535, 1'b0),
         sample_row(32'd0, 32'd65536, 1'b0),
         sample_row(32'd0, -32'sd65536, 1'b0),
         // zero tick, and a write to the unused index that must not land
         wr_row(xysq_pkg::CSR_TICK_TIME, 16'd0),
         wr_row(CSR_UNUSED, 16'd5),
         sample_row(32'd0, 32'd0, 1'b1),
         sample_row(32'd0, 32'd0, 1'b0),
         checked_row(32'd0, 32'd131072, 1'b0, xysq_pkg::STEP_PY, 32'd0)
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan_rows[i]) run_row(plan_rows[i]);

      // run with no step so the elapsed time builds up, then one step reports it
      run_row(wr_row(xysq_pkg::CSR_STEP_SIZE_X, 16'hFFFF));
      run_row(wr_row(xysq_pkg::CSR_STEP_SIZE_Y, 16'hFFFF));
      run_row(wr_row(xysq_pkg::CSR_TICK_TIME, 16'hFFFF));
      run_row(sample_row(32'd0, 32'd0, 1'b1));
      repeat (QUIET_RUN) run_row(sample_row(32'd0, 32'd0, 1'b0));
      run_row(sample_row(32'd65536, 32'd0, 1'b0));

      // random part: mostly moves that walk in steps near the step size,
      // some raw noise, registers changed now and then between segments
      while (random_count < RANDOM_ITEMS) begin
         if ($urandom_range(0, 4) == 0) begin
            if ($urandom_range(0, 1))
               run_row(wr_row(xysq_pkg::CSR_STEP_SIZE_X, pick_setting()));
            if ($urandom_range(0, 1))
               run_row(wr_row(xysq_pkg::CSR_STEP_SIZE_Y, pick_setting()));
            if ($urandom_range(0, 1))
               run_row(wr_row(xysq_pkg::CSR_TICK_TIME, pick_setting()));
            if ($urandom_range(0, 7) == 0) run_row(wr_row(CSR_UNUSED, 16'($urandom)));
         end
         seg_len = $urandom_range(5, 40);
         wander  = $urandom_range(0, 4) != 0;
         first   = 1'b1;
         walk_x  = 0;
         walk_y  = 0;
         // sometimes the move begins far from its origin
         if ($urandom_range(0, 5) == 0) begin
            walk_x = $signed($urandom);
            walk_y = $signed($urandom);
         end
         repeat (seg_len) begin
            if (wander) begin
               span   = 3 * longint'(size_x) + 2;
               walk_x = clamp_pos(walk_x + longint'($urandom_range(0, 32'(2 * span))) - span);
               span   = 3 * longint'(size_y) + 2;
               walk_y = clamp_pos(walk_y + longint'($urandom_range(0, 32'(2 * span))) - span);
               run_row(sample_row(32'(walk_x), 32'(walk_y),
                                  first || ($urandom_range(0, 29) == 0)));
            end else begin
               run_row(sample_row($urandom, $urandom, 1'($urandom_range(0, 1))));
            end
            first = 1'b0;
            random_count++;
            if (random_count == PRESSURE_AT) pressure_due = 1'b1;
            if (random_count == RANDOM_ITEMS - CALM_TAIL) calm = 1'b1;
         end
      end

      settle();
      if (fault_count == 0) begin
         $display("xy_step_direction_quantizer_core_test: clean");
      end else begin
         $display("xy_step_direction_quantizer_core_test: errors");
      end
      $finish;
   end

endmodule

[filelist.f]
design/xysq_pkg.sv
design/xysq_axis.sv
design/xysq_elapsed.sv
design/xy_step_direction_quantizer_core.sv
design/xysq_checker.sv
test/xy_step_direction_quantizer_core_test.sv
